### hw/rtl/lcdn_pkg.sv
package lcdn_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_ENABLE_SETUP = 2'd0;
  localparam logic [1:0] CFG_ENABLE_HIGH  = 2'd1;
  localparam logic [1:0] CFG_SETTLE       = 2'd2;

  localparam logic [9:0] SETUP_RESET  = 10'd1;
  localparam logic [9:0] HIGH_RESET   = 10'd1;
  localparam logic [9:0] SETTLE_RESET = 10'd100;

  localparam int QUEUE_DEPTH = 2;

  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = 6'd40;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 6'd5;

  localparam logic [15:0] PWR_WAIT_US   = 16'd50000;
  localparam logic [15:0] WAIT_FIRST_US = 16'd5000;
  localparam logic [15:0] WAIT_SHORT_US = 16'd1000;
  localparam logic [15:0] CLEAR_WAIT_US = 16'd2000;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_CMD  = 2'd1,
    OP_DATA = 2'd2
  } op_kind_t;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_SETUP,
    PH_HIGH,
    PH_SETTLE
  } phase_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] byte_val;
  } lcdn_req_t;

  // front -> queue
  typedef struct packed {
    logic      push;
    lcdn_req_t req;
  } lcdn_push_t;

  // queue -> back
  typedef struct packed {
    logic      valid;
    lcdn_req_t req;
  } lcdn_head_t;

  typedef struct packed {
    phase_kind_t kind;
    logic [3:0]  nib;
    logic [15:0] wait_us;
  } lcdn_phase_t;

  // Position of a step inside a nibble transfer
  function automatic phase_kind_t nib_phase(input logic [1:0] pos);
    phase_kind_t k;
    case (pos)
      2'd0:    k = PH_SETUP;
      2'd1:    k = PH_HIGH;
      default: k = PH_SETTLE;
    endcase
    return k;
  endfunction

  // Power-up init script, one entry per output phase
  function automatic lcdn_phase_t init_phase(input logic [STEP_W-1:0] step);
    lcdn_phase_t       ph;
    logic [STEP_W-1:0] base;
    logic [STEP_W-1:0] pos;
    logic              is_wait;
    ph.kind    = PH_WAIT;
    ph.nib     = 4'h0;
    ph.wait_us = 16'd0;
    base       = '0;
    is_wait    = 1'b1;
    case (step) inside
      6'd0:                ph.wait_us = PWR_WAIT_US;
      6'd4:                ph.wait_us = WAIT_FIRST_US;
      6'd8, 6'd12:         ph.wait_us = WAIT_SHORT_US;
      6'd34:               ph.wait_us = CLEAR_WAIT_US;
      [6'd1:6'd3]:   begin base = 6'd1;  ph.nib = 4'h3; is_wait = 1'b0; end
      [6'd5:6'd7]:   begin base = 6'd5;  ph.nib = 4'h3; is_wait = 1'b0; end
      [6'd9:6'd11]:  begin base = 6'd9;  ph.nib = 4'h3; is_wait = 1'b0; end
      [6'd13:6'd15]: begin base = 6'd13; ph.nib = 4'h2; is_wait = 1'b0; end
      // function set 0x28
      [6'd16:6'd18]: begin base = 6'd16; ph.nib = 4'h2; is_wait = 1'b0; end
      [6'd19:6'd21]: begin base = 6'd19; ph.nib = 4'h8; is_wait = 1'b0; end
      // display on 0x0c
      [6'd22:6'd24]: begin base = 6'd22; ph.nib = 4'h0; is_wait = 1'b0; end
      [6'd25:6'd27]: begin base = 6'd25; ph.nib = 4'hc; is_wait = 1'b0; end
      // clear 0x01
      [6'd28:6'd30]: begin base = 6'd28; ph.nib = 4'h0; is_wait = 1'b0; end
      [6'd31:6'd33]: begin base = 6'd31; ph.nib = 4'h1; is_wait = 1'b0; end
      // entry mode 0x06
      [6'd35:6'd37]: begin base = 6'd35; ph.nib = 4'h0; is_wait = 1'b0; end
      [6'd38:6'd40]: begin base = 6'd38; ph.nib = 4'h6; is_wait = 1'b0; end
      default:             ph.wait_us = 16'd0;
    endcase
    pos = step - base;
    if (!is_wait) begin
      ph.kind = nib_phase(pos[1:0]);
    end
    return ph;
  endfunction

endpackage

### hw/rtl/lcdn_front.sv
module lcdn_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_byte_value,
  input  logic                  q_full,
  output lcdn_pkg::lcdn_push_t  push
);

  // Unused operation code is taken and dropped unless the queue is full.
  always_comb begin
    in_stall          = q_full;
    push.req.byte_val = in_byte_value;
    push.req.kind     = lcdn_pkg::OP_INIT;
    push.push         = 1'b0;
    case (in_operation)
      lcdn_pkg::OP_INIT,
      lcdn_pkg::OP_CMD,
      lcdn_pkg::OP_DATA: begin
        push.req.kind = lcdn_pkg::op_kind_t'(in_operation);
        push.push     = in_valid && !q_full;
      end
      default: push.push = 1'b0;
    endcase
  end

endmodule

### hw/rtl/lcdn_queue.sv
module lcdn_queue #(
  parameter int DEPTH = lcdn_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdn_pkg::lcdn_push_t push,
  output logic                 q_full,
  output lcdn_pkg::lcdn_head_t head,
  input  logic                 pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lcdn_pkg::lcdn_req_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_full     = (cnt_r == FULL_CNT);
  assign head.valid = (cnt_r != '0);
  assign head.req   = slot_r[rd_ptr_r];

  always_comb begin
    do_push    = push.push && !q_full;
    do_pop     = pop && head.valid;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.req;
    end
  end

endmodule

### hw/rtl/lcdn_back.sv
module lcdn_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [9:0]           setup_us,
  input  logic [9:0]           high_us,
  input  logic [9:0]           settle_us,
  input  lcdn_pkg::lcdn_head_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_rs_pin,
  output logic                 out_enable_pin,
  output logic [3:0]           out_nibble,
  output logic [15:0]          out_hold_us,
  output logic                 out_last
);

  logic [lcdn_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [3:0]                  data_nibble_r, data_nibble_nxt;
  logic                        rs_r, en_r, last_r;
  logic [3:0]                  nib_r;
  logic [15:0]                 hold_r;

  lcdn_pkg::lcdn_phase_t       ph;
  logic                        adv, fire, is_last;
  logic [lcdn_pkg::STEP_W-1:0] byte_pos;
  logic                        rs_cur;
  logic [3:0]                  nib_cur;
  logic [15:0]                 hold_cur;

  always_comb begin
    adv      = !out_valid_r || !out_stall;
    fire     = adv && head.valid;
    byte_pos = (step_r < 6'd3) ? step_r : step_r - 6'd3;
    if (head.req.kind == lcdn_pkg::OP_INIT) begin
      ph      = lcdn_pkg::init_phase(step_r);
      is_last = (step_r == lcdn_pkg::INIT_LAST_STEP);
      rs_cur  = 1'b0;
    end else begin
      ph.kind    = lcdn_pkg::nib_phase(byte_pos[1:0]);
      ph.nib     = (step_r < 6'd3) ? head.req.byte_val[7:4] : head.req.byte_val[3:0];
      ph.wait_us = 16'd0;
      is_last    = (step_r == lcdn_pkg::BYTE_LAST_STEP);
      rs_cur     = (head.req.kind == lcdn_pkg::OP_DATA);
    end
    // wait phases keep the lines as they are
    nib_cur = (ph.kind == lcdn_pkg::PH_WAIT) ? data_nibble_r : ph.nib;
    case (ph.kind)
      lcdn_pkg::PH_SETUP:  hold_cur = {6'd0, setup_us};
      lcdn_pkg::PH_HIGH:   hold_cur = {6'd0, high_us};
      lcdn_pkg::PH_SETTLE: hold_cur = {6'd0, settle_us};
      default:             hold_cur = ph.wait_us;
    endcase

    pop             = fire && is_last;
    step_nxt        = step_r;
    data_nibble_nxt = data_nibble_r;
    out_valid_nxt   = out_valid_r;
    if (fire) begin
      step_nxt        = is_last ? '0 : step_r + 1'b1;
      data_nibble_nxt = nib_cur;
      out_valid_nxt   = 1'b1;
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= '0;
      out_valid_r   <= 1'b0;
      data_nibble_r <= 4'h0;
    end else begin
      step_r        <= step_nxt;
      out_valid_r   <= out_valid_nxt;
      data_nibble_r <= data_nibble_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rs_r   <= rs_cur;
      en_r   <= (ph.kind == lcdn_pkg::PH_HIGH);
      nib_r  <= nib_cur;
      hold_r <= hold_cur;
      last_r <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rs_pin     = rs_r;
  assign out_enable_pin = en_r;
  assign out_nibble     = nib_r;
  assign out_hold_us    = hold_r;
  assign out_last       = last_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= lcdn_pkg::INIT_LAST_STEP)
    else $error("sequencer step out of range");

  a_mid_op_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != '0 |-> head.valid)
    else $error("sequencer mid-operation with empty queue");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> step_r == '0)
    else $error("step not cleared after final phase");

  a_enable_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ph.kind == lcdn_pkg::PH_HIGH |=> out_enable_pin && out_hold_us == {6'd0, high_us})
    else $error("enable-high phase hold mismatch");

endmodule

### hw/rtl/char_lcd_nibble_interface.sv
// An accepted request is written into the queue, then from the queue head into the output register.
// The sequencer emits one pin phase per cycle while out_stall is low; a command or data
//   byte is 6 pin phases, the init sequence 41.
// A two-entry request queue lets new requests be taken while phases are still going out.
// Reset (rst_n, synchronous, active low): queue empty, output invalid, config registers
//   at setup 1 us, enable-high 1 us, settle 100 us; driven data nibble cleared.
module char_lcd_nibble_interface #(
  parameter int QUEUE_DEPTH = lcdn_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_byte_value,
  // pin phase channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_rs_pin,
  output logic        out_enable_pin,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_hold_us,
  output logic        out_last,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  logic [9:0] setup_us_r, high_us_r, settle_us_r;
  logic       q_full, pop;

  lcdn_pkg::lcdn_push_t push;
  lcdn_pkg::lcdn_head_t head;

  // Config writes always accepted; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_us_r  <= lcdn_pkg::SETUP_RESET;
      high_us_r   <= lcdn_pkg::HIGH_RESET;
      settle_us_r <= lcdn_pkg::SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcdn_pkg::CFG_ENABLE_SETUP: setup_us_r  <= cfg_data;
        lcdn_pkg::CFG_ENABLE_HIGH:  high_us_r   <= cfg_data;
        lcdn_pkg::CFG_SETTLE:       settle_us_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: decode and accept requests
  lcdn_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_byte_value (in_byte_value),
    .q_full        (q_full),
    .push          (push)
  );

  // Request queue between front and sequencer
  lcdn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .q_full (q_full),
    .head   (head),
    .pop    (pop)
  );

  // Back: phase sequencer with output register
  lcdn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .setup_us       (setup_us_r),
    .high_us        (high_us_r),
    .settle_us      (settle_us_r),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_rs_pin     (out_rs_pin),
    .out_enable_pin (out_enable_pin),
    .out_nibble     (out_nibble),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last)
  );

endmodule
